>>> rtl/core/b64_pkg.sv
package b64_pkg;

    localparam logic [6:0] PAD_CHAR = 7'd61;
    localparam logic [2:0] FULL_CHARS = 3'd4;

    // one group handed from the packer to the emitter
    typedef struct packed {
        logic [23:0] bits;   // first byte in bits 23..16
        logic [2:0]  ndig;   // digits carrying data, 2 to 4
        logic [2:0]  nchar;  // characters in total, 2 to 4
        logic        last;   // group ends the message
    } b64_grp_t;

    // standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] ch;
        if (v < 6'd26)
        begin
            ch = 7'd65 + {1'b0, v};
        end
        else if (v < 6'd52)
        begin
            ch = 7'd71 + {1'b0, v};
        end
        else if (v < 6'd62)
        begin
            ch = {1'b0, v} - 7'd4;
        end
        else if (v == 6'd62)
        begin
            ch = 7'd43;
        end
        else
        begin
            ch = 7'd47;
        end
        return ch;
    endfunction

endpackage

>>> rtl/core/b64_pack.sv
module b64_pack
    import b64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pad_enable,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       grp_valid,
    input  logic       grp_pop,
    output b64_grp_t   grp
);

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] held_reg, held_next;
    logic        pend_valid_reg, pend_valid_next;
    b64_grp_t    pend_reg, pend_next;

    logic [23:0] bits_w;
    logic [1:0]  have_w;
    logic        accept;
    logic        flush;

    assign in_ready  = !pend_valid_reg || grp_pop;
    assign accept    = in_valid && in_ready;
    assign grp_valid = pend_valid_reg;
    assign grp       = pend_reg;

    always_comb
    begin
        unique case (phase_reg)
            2'd1:
            begin
                bits_w = {held_reg[15:8], in_byte, 8'h00};
                have_w = 2'd2;
            end
            2'd2:
            begin
                bits_w = {held_reg, in_byte};
                have_w = 2'd3;
            end
            default:
            begin
                bits_w = {in_byte, 16'h0000};
                have_w = 2'd1;
            end
        endcase
    end

    assign flush = (have_w == 2'd3) || in_last;

    always_comb
    begin
        phase_next      = phase_reg;
        held_next       = held_reg;
        pend_valid_next = pend_valid_reg && !grp_pop;
        pend_next       = pend_reg;
        if (accept)
        begin
            if (flush)
            begin
                phase_next      = 2'd0;
                held_next       = 16'h0000;
                pend_valid_next = 1'b1;
                pend_next.bits  = bits_w;
                pend_next.last  = in_last;
                if (have_w == 2'd3)
                begin
                    pend_next.ndig  = FULL_CHARS;
                    pend_next.nchar = FULL_CHARS;
                end
                else
                begin
                    pend_next.ndig  = {1'b0, have_w} + 3'd1;
                    pend_next.nchar = pad_enable ? FULL_CHARS : ({1'b0, have_w} + 3'd1);
                end
            end
            else
            begin
                phase_next = have_w;
                held_next  = bits_w[23:8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 2'd0;
            held_reg       <= 16'h0000;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_reg       <= held_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("group phase out of range");

    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !grp_pop |=> pend_valid_reg && $stable(pend_reg))
        else $error("pending group lost before pop");

    a_pend_shape: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> pend_reg.ndig >= 3'd2 && pend_reg.nchar >= pend_reg.ndig
                           && pend_reg.nchar <= FULL_CHARS)
        else $error("malformed pending group");

endmodule

>>> rtl/core/b64_emit.sv
module b64_emit
    import b64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       grp_valid,
    output logic       grp_pop,
    input  b64_grp_t   grp,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] out_char,
    output logic       out_last
);

    logic       cur_valid_reg, cur_valid_next;
    b64_grp_t   cur_reg;
    logic [1:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;
    logic [6:0] oc_reg, oc_next;
    logic       ol_reg, ol_next;

    logic       advance;
    logic       at_end;
    logic [5:0] digit;

    assign advance = !ov_reg || out_ready;
    assign at_end  = ({1'b0, idx_reg} == (cur_reg.nchar - 3'd1));
    assign grp_pop = grp_valid && (!cur_valid_reg || (advance && at_end));

    always_comb
    begin
        unique case (idx_reg)
            2'd0: digit = cur_reg.bits[23:18];
            2'd1: digit = cur_reg.bits[17:12];
            2'd2: digit = cur_reg.bits[11:6];
            default: digit = cur_reg.bits[5:0];
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        ov_next        = ov_reg;
        oc_next        = oc_reg;
        ol_next        = ol_reg;
        if (advance)
        begin
            ov_next = cur_valid_reg;
            if (cur_valid_reg)
            begin
                oc_next = ({1'b0, idx_reg} < cur_reg.ndig) ? b64_char(digit) : PAD_CHAR;
                ol_next = cur_reg.last && at_end;
                idx_next = idx_reg + 2'd1;
                if (at_end)
                begin
                    cur_valid_next = 1'b0;
                end
            end
        end
        if (grp_pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oc_reg <= oc_next;
        ol_reg <= ol_next;
        if (grp_pop)
        begin
            cur_reg <= grp;
        end
    end

    assign out_valid = ov_reg;
    assign out_char  = oc_reg;
    assign out_last  = ol_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> ({1'b0, idx_reg} < cur_reg.nchar))
        else $error("character index past group end");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ready |=> ov_reg && $stable(oc_reg) && $stable(ol_reg))
        else $error("stalled character changed");

    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        grp_pop |-> !cur_valid_reg || (advance && at_end))
        else $error("group loaded over a busy one");

endmodule

>>> rtl/core/base64_encoder.sv
// Streaming base64 encoder with the standard alphabet (A-Z a-z 0-9 + /). Raw message
// bytes come in on the slave stream, one item per byte, with s_tlast on the final byte
// of a message; ASCII characters go out on the master stream, with m_tlast on the final
// character. Every three bytes give four characters; the byte marked last flushes a
// partial group as two or three characters, followed by '=' up to four when pad_enable
// is set (reset value 1, written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce). A byte is taken
// whenever the one-group hand-off slot is free; while a finished group waits in that slot
// for the emitter, every byte waits too, whether it finishes a group or not. The output
// register delivers one character per cycle unless m_tready stalls it, so a sustained
// stream is limited by the single character output register.
module base64_encoder
    import b64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_we,
    input  logic       cfg_wdata,     // pad_enable

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] data_byte
    input  logic       s_tlast,       // last_byte

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [6:0] out_char, [7] zero
    output logic       m_tlast        // last_char
);

    // padding mode register
    logic pad_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            pad_enable_reg <= cfg_wdata;
        end
    end

    // packer to emitter hand-off
    logic     grp_valid;
    logic     grp_pop;
    b64_grp_t grp;
    logic [6:0] out_char;

    // gathers bytes into 24-bit groups and holds one finished group
    b64_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .pad_enable (pad_enable_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .grp_valid  (grp_valid),
        .grp_pop    (grp_pop),
        .grp        (grp)
    );

    // turns a group into characters, one per cycle while out_ready allows, into the output register
    b64_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp_pop   (grp_pop),
        .grp       (grp),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    // ascii is seven bits, top bit of the byte is always clear
    assign m_tdata = {1'b0, out_char};

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import b64_pkg::*;

    // run limit in clock cycles, far above the slowest legal run
    localparam int CYCLE_LIMIT = 200000;

    // base64 digits, first digit in the top byte
    localparam logic [511:0] DIGIT_TABLE =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // one expected output character
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } enc_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;

    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;      // [7:0] data_byte
    logic       s_tlast = 1'b0;       // last_byte

    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;              // [6:0] out_char, [7] zero
    logic       m_tlast;              // last_char

    // encoder state as the testbench sees it
    logic [1:0] enc_phase = 2'd0;
    logic [15:0] enc_held = 16'h0000;
    logic       enc_pad = 1'b1;

    enc_char_t  pending_chars[$];
    enc_char_t  want;
    int         error_count = 0;
    int         cycle_count = 0;
    bit         quiet = 1'b0;         // no idling on either side while set

    base64_encoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #6 clk = ~clk;

    // ascii code of one base64 digit
    function automatic logic [6:0] digit_char(input logic [5:0] v);
        return DIGIT_TABLE[504 - 8 * int'(v) +: 7];
    endfunction

    task automatic queue_char(input logic [6:0] ch, input logic last_in);
        enc_char_t c;
        c.ch = ch;
        c.last = last_in;
        pending_chars = {pending_chars, c};
    endtask

    // update the encoder state for one accepted byte and queue the characters it yields
    task automatic encode_byte(input logic [7:0] data, input logic last_in);
        logic [23:0] grp;
        int have;
        int ndig;
        case (enc_phase)
            2'd1:
            begin
                enc_held = {enc_held[15:8], data};
                grp = {enc_held, 8'h00};
                have = 2;
            end
            2'd2:
            begin
                grp = {enc_held, data};
                have = 3;
            end
            default:
            begin
                // phase 3 never happens, it behaves as a fresh group
                enc_held = {data, 8'h00};
                grp = {data, 16'h0000};
                have = 1;
            end
        endcase
        if (have == 3)
        begin
            // full group: four digits, the last mark rides on the fourth
            for (int i = 0; i < 4; i++)
                queue_char(digit_char(grp[18 - 6 * i +: 6]), (i == 3) && last_in);
            enc_phase = 2'd0;
            enc_held = 16'h0000;
        end
        else if (!last_in)
        begin
            enc_phase = have[1:0];
        end
        else
        begin
            // partial group flushed by the last byte
            ndig = have + 1;
            for (int i = 0; i < ndig; i++)
                queue_char(digit_char(grp[18 - 6 * i +: 6]), (i == ndig - 1) && !enc_pad);
            if (enc_pad)
            begin
                for (int i = ndig; i < 4; i++)
                    queue_char(PAD_CHAR, i == 3);
            end
            enc_phase = 2'd0;
            enc_held = 16'h0000;
        end
    endtask

    // offer one byte, wait for the handshake, then predict; call at a rising edge
    task automatic push_byte(input logic [7:0] data, input logic last_in);
        if (!quiet && $urandom_range(0, 99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tlast <= last_in;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        encode_byte(data, last_in);
    endtask

    // stop sending and let every expected character come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_pad(input logic val);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        enc_pad = val;
    endtask

    // random messages, mostly short, some spanning several groups
    task automatic random_messages(input int byte_budget);
        int sent;
        int len;
        logic [7:0] d;
        sent = 0;
        while (sent < byte_budget)
        begin
            if ($urandom_range(0, 9) < 7)
                len = $urandom_range(1, 6);
            else
                len = $urandom_range(7, 20);
            for (int k = 0; k < len; k++)
            begin
                case ($urandom_range(0, 9))
                    0: d = 8'h00;
                    1: d = 8'hff;
                    default: d = 8'($urandom_range(0, 255));
                endcase
                push_byte(d, k == len - 1);
            end
            sent += len;
        end
    endtask

    // padding on from reset: one and two byte flushes, a message ending on a full group
    task automatic test_padded_flush();
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b1);
        push_byte(8'hfb, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'hbf, 1'b1);
        push_byte(8'h14, 1'b0);
        push_byte(8'hfb, 1'b0);
        push_byte(8'h9c, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'hd9, 1'b0);
        push_byte(8'h7e, 1'b1);
    endtask

    // padding off: last mark moves onto the final data digit
    task automatic test_unpadded_flush();
        drain();
        write_pad(1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h7f, 1'b1);
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h01, 1'b1);
    endtask

    task automatic test_random_padded();
        drain();
        write_pad(1'b1);
        random_messages(120);
    endtask

    task automatic test_random_unpadded();
        drain();
        write_pad(1'b0);
        random_messages(110);
    endtask

    // back to back on both sides for a long stretch
    task automatic test_random_no_idle();
        drain();
        write_pad(1'b1);
        quiet = 1'b1;
        random_messages(110);
        drain();
        quiet = 1'b0;
    endtask

    // sink side: stalls at random, never while quiet
    always @(posedge clk)
    begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 8);
    end

    // compare each delivered character with the oldest one predicted
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected item, actual tdata=%h tlast=%b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (m_tdata !== {1'b0, want.ch})
                begin
                    $display("%0t: out_char mismatch, expected %h actual %h",
                             $time, {1'b0, want.ch}, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last_char mismatch, expected %b actual %b",
                             $time, want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_padded_flush();
        test_unpadded_flush();
        test_random_padded();
        test_random_unpadded();
        test_random_no_idle();

        // everything delivered, then a short wait for stray output
        drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> base64_encoder.f
rtl/core/b64_pkg.sv
rtl/core/b64_pack.sv
rtl/core/b64_emit.sv
rtl/core/base64_encoder.sv
test/tb_top.sv
